@@ design/rtsg_pkg.sv @@
// shared constants, state codes and control structs for the sack gap tracker
`default_nettype none
package rtsg_pkg;

    localparam int SEQ_W      = 32;
    localparam int WINDOW     = 64;
    localparam int WIN_IDX_W  = $clog2(WINDOW);
    localparam int K_W        = $clog2(WINDOW + 1);
    localparam int OFS_W      = 7;
    localparam int MAX_BLOCKS = 32;
    localparam int NBLK_W     = $clog2(MAX_BLOCKS);

    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_INITIAL_TSN = REG_IDX_W'(0);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ADV,
        S_LOAD,
        S_SCAN
    } t_state;

    // sequencer to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic adv;
        logic load;
        logic scan;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic d_zero;
        logic map0;
        logic scan_done;
    } t_stat;

endpackage
`default_nettype wire

@@ design/rtsg_in_if.sv @@
// input channel carrying the arriving chunk sequence number
`default_nettype none
interface rtsg_in_if import rtsg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_num;

    modport source (output valid, output seq_num, input ready);
    modport sink   (input valid, input seq_num, output ready);
endinterface
`default_nettype wire

@@ design/rtsg_out_if.sv @@
// output channel carrying one sack word
`default_nettype none
interface rtsg_out_if import rtsg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] cum_ack;
    logic             duplicate;
    logic             out_of_window;
    logic             gap_valid;
    logic [OFS_W-1:0] gap_start;
    logic [OFS_W-1:0] gap_end;
    logic             last;

    modport source (output valid, output cum_ack, output duplicate, output out_of_window,
                    output gap_valid, output gap_start, output gap_end, output last,
                    input ready);
    modport sink   (input valid, input cum_ack, input duplicate, input out_of_window,
                    input gap_valid, input gap_start, input gap_end, input last,
                    output ready);
endinterface
`default_nettype wire

@@ design/rtsg_cfg.sv @@
// apb register port holding the initial sequence number
`default_nettype none
module rtsg_cfg import rtsg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic                    o_cfg_wr,
    output logic      [SEQ_W-1:0]   o_cfg_tsn
);

    logic [SEQ_W-1:0] r_initial_tsn;
    logic             hit;

    assign hit      = (paddr[PADDR_W-1:2] == REG_INITIAL_TSN);
    assign pready   = 1'b1;
    assign o_cfg_wr = psel && penable && pwrite && hit;
    assign o_cfg_tsn = pwdata[SEQ_W-1:0];
    assign prdata   = hit ? PDATA_W'(r_initial_tsn) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_tsn <= '0;
        end else if (o_cfg_wr) begin
            r_initial_tsn <= o_cfg_tsn;
        end
    end

endmodule
`default_nettype wire

@@ design/rtsg_ctrl.sv @@
// sequencer stepping one chunk through evaluate, advance and gap scan
`default_nettype none
module rtsg_ctrl import rtsg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_ctrl      o_ctrl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_stat.d_zero ? S_ADV : S_LOAD;
            end
            S_ADV: begin
                if (!i_stat.map0) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.capture = i_in_valid;
            end
            S_EVAL:  o_ctrl.eval = 1'b1;
            S_ADV:   o_ctrl.adv  = 1'b1;
            S_LOAD:  o_ctrl.load = 1'b1;
            S_SCAN:  o_ctrl.scan = 1'b1;
            default: o_ctrl = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/rtsg_dp.sv @@
// tracker state, shared one-bit map shifter, run scan and output register
`default_nettype none
module rtsg_dp import rtsg_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [SEQ_W-1:0] i_seq_num,
    input  wire logic             i_cfg_wr,
    input  wire logic [SEQ_W-1:0] i_cfg_tsn,
    input  wire logic             i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic      [SEQ_W-1:0] o_cum_ack,
    output logic                  o_duplicate,
    output logic                  o_out_of_window,
    output logic                  o_gap_valid,
    output logic      [OFS_W-1:0] o_gap_start,
    output logic      [OFS_W-1:0] o_gap_end,
    output logic                  o_last
);

    logic [SEQ_W-1:0]     r_seq;
    logic [SEQ_W-1:0]     r_next_exp, n_next_exp;
    logic [WINDOW-1:0]    r_map, n_map;
    logic [WINDOW-1:0]    r_work, n_work;
    logic [K_W-1:0]       r_k, n_k;
    logic [K_W-1:0]       r_start, n_start;
    logic                 r_in_run, n_in_run;
    logic [NBLK_W-1:0]    r_nblk, n_nblk;
    logic                 r_dup, r_oow;
    logic [SEQ_W-1:0]     r_cum;
    logic                 r_ov;

    logic [SEQ_W-1:0]     d;
    logic [WIN_IDX_W-1:0] widx;
    logic                 d_zero, behind, beyond, inwin, hit;
    logic [WINDOW-1:0]    shift_in, shift_out;
    logic                 emit_blk, emit_empty, emit, last_blk, out_free, step;

    // window offset, modulo 2^32
    assign d      = r_seq - r_next_exp;
    assign widx   = d[WIN_IDX_W-1:0];
    assign d_zero = (d == '0);
    assign behind = d[SEQ_W-1];
    assign beyond = !behind && (d >= SEQ_W'(WINDOW));
    assign inwin  = !d_zero && !behind && !beyond;
    assign hit    = r_map[widx];

    // the one shifter, shared by the cumulative advance, the scan load and the scan
    assign shift_in  = (i_ctrl.adv || i_ctrl.load) ? r_map : r_work;
    assign shift_out = shift_in >> 1;

    assign emit_blk   = r_in_run && !r_work[0];
    assign emit_empty = !r_in_run && (r_work == '0);
    assign last_blk   = (r_work[WINDOW-1:1] == '0) || (r_nblk == NBLK_W'(MAX_BLOCKS - 1));
    assign emit       = i_ctrl.scan && (emit_blk || emit_empty);
    assign out_free   = !r_ov || i_out_ready;
    assign step       = i_ctrl.scan && (!emit || out_free);

    assign o_stat.d_zero    = d_zero;
    assign o_stat.map0      = r_map[0];
    assign o_stat.scan_done = emit && out_free && (emit_empty || last_blk);

    always_comb begin
        n_next_exp = r_next_exp;
        n_map      = r_map;
        if (i_cfg_wr) begin
            n_next_exp = i_cfg_tsn;
            n_map      = '0;
        end else if (i_ctrl.eval) begin
            if (d_zero) begin
                n_map[0] = 1'b1;
            end else if (inwin && !hit) begin
                n_map[widx] = 1'b1;
            end
        end else if (i_ctrl.adv && r_map[0]) begin
            n_map      = shift_out;
            n_next_exp = r_next_exp + SEQ_W'(1);
        end
    end

    always_comb begin
        n_work   = r_work;
        n_k      = r_k;
        n_start  = r_start;
        n_in_run = r_in_run;
        n_nblk   = r_nblk;
        if (i_ctrl.load) begin
            n_work   = shift_out;
            n_k      = K_W'(1);
            n_in_run = 1'b0;
            n_nblk   = '0;
        end else if (step) begin
            n_work = shift_out;
            n_k    = r_k + K_W'(1);
            if (emit_blk) begin
                n_in_run = 1'b0;
                n_nblk   = r_nblk + NBLK_W'(1);
            end else if (r_work[0] && !r_in_run) begin
                n_start  = r_k;
                n_in_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_exp <= '0;
            r_map      <= '0;
            r_in_run   <= 1'b0;
            r_nblk     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_next_exp <= n_next_exp;
            r_map      <= n_map;
            r_in_run   <= n_in_run;
            r_nblk     <= n_nblk;
            if (emit && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_k     <= n_k;
        r_start <= n_start;
        if (i_ctrl.capture) r_seq <= i_seq_num;
        if (i_ctrl.eval) begin
            r_dup <= behind || (inwin && hit);
            r_oow <= beyond;
        end
        if (i_ctrl.load) r_cum <= r_next_exp - SEQ_W'(1);
        if (emit && out_free) begin
            o_cum_ack       <= r_cum;
            o_duplicate     <= r_dup;
            o_out_of_window <= r_oow;
            o_gap_valid     <= emit_blk;
            o_gap_start     <= emit_blk ? OFS_W'(r_start + K_W'(1)) : '0;
            o_gap_end       <= emit_blk ? OFS_W'(r_k) : '0;
            o_last          <= emit_empty || last_blk;
        end
    end

    assign o_valid = r_ov;

endmodule
`default_nettype wire

@@ design/rx_tsn_tracker_sack_gaps.sv @@
// receive sequence tracker top level: apb register, sequencer and datapath
// path to the first word: the chunk is captured and evaluated; for an in-order chunk the
// cumulative point then advances while the map holds the next number, and the scan is
// loaded and walks the map position by position up to the end of the lowest gap block;
// later words follow as the scan goes on; one chunk at a time, taken only when idle;
// the single map shifter serves advance, load and scan, and back-pressure stalls the scan
// reset (synchronous, active low): expected number and initial tsn go to 0,
// received map clears, no word pending on the output
`default_nettype none
module rx_tsn_tracker_sack_gaps import rtsg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    rtsg_in_if.sink                 i_chunk,
    rtsg_out_if.source              o_sack
);

    // configuration write, also reloads the tracker state
    logic             cfg_wr;
    logic [SEQ_W-1:0] cfg_tsn;

    // sequencer handshake with the datapath
    t_ctrl ctrl;
    t_stat stat;

    rtsg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg_wr  (cfg_wr),
        .o_cfg_tsn (cfg_tsn)
    );

    // idle -> evaluate offset -> advance cumulative point (in-order chunk only) -> load scan -> scan runs
    rtsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_chunk.valid),
        .i_stat     (stat),
        .o_in_ready (i_chunk.ready),
        .o_ctrl     (ctrl)
    );

    // one gap block per output word, last word flagged; empty sack when no gaps
    rtsg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_seq_num       (i_chunk.seq_num),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_tsn       (cfg_tsn),
        .i_out_ready     (o_sack.ready),
        .o_stat          (stat),
        .o_valid         (o_sack.valid),
        .o_cum_ack       (o_sack.cum_ack),
        .o_duplicate     (o_sack.duplicate),
        .o_out_of_window (o_sack.out_of_window),
        .o_gap_valid     (o_sack.gap_valid),
        .o_gap_start     (o_sack.gap_start),
        .o_gap_end       (o_sack.gap_end),
        .o_last          (o_sack.last)
    );

endmodule
`default_nettype wire

@@ design/rtsg_checker.sv @@
// port-level checks on the sack output stream, bound to the top level
`default_nettype none
module rtsg_checker import rtsg_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [SEQ_W-1:0] i_cum_ack,
    input wire logic             i_duplicate,
    input wire logic             i_out_of_window,
    input wire logic             i_gap_valid,
    input wire logic [OFS_W-1:0] i_gap_start,
    input wire logic [OFS_W-1:0] i_gap_end,
    input wire logic             i_last
);

    // nothing pending once reset has been seen
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_cum_ack, i_duplicate, i_out_of_window, i_gap_valid,
                     i_gap_start, i_gap_end, i_last}))
        else $error("stalled output word changed");

    // a sack without gaps is a single final word with zeroed gap bounds
    a_empty_sack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_gap_valid |-> i_last && i_gap_start == '0 && i_gap_end == '0)
        else $error("gapless word malformed");

    a_block_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_gap_valid |-> i_gap_start != '0 && i_gap_start <= i_gap_end)
        else $error("gap block bounds out of order");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_duplicate && i_out_of_window))
        else $error("duplicate and out of window both set");

endmodule

bind rx_tsn_tracker_sack_gaps rtsg_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_sack.valid),
    .i_out_ready     (o_sack.ready),
    .i_cum_ack       (o_sack.cum_ack),
    .i_duplicate     (o_sack.duplicate),
    .i_out_of_window (o_sack.out_of_window),
    .i_gap_valid     (o_sack.gap_valid),
    .i_gap_start     (o_sack.gap_start),
    .i_gap_end       (o_sack.gap_end),
    .i_last          (o_sack.last)
);
`default_nettype wire
